### hdl/hrlc_pkg.sv
package hrlc_pkg;

	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [POS_W-1:0] GET_LEN = 4'd3;
	localparam logic [POS_W-1:0] POST_LEN = 4'd4;
	localparam logic [POS_W-1:0] HEAD_LEN = 4'd4;
	localparam logic [POS_W-1:0] VER_LEN = 4'd8;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam logic [2:0] M_GET = 3'b001;
	localparam logic [2:0] M_POST = 3'b010;
	localparam logic [2:0] M_HEAD = 3'b100;

	typedef enum logic [1:0] {
		FLD_METHOD = 2'd0,
		FLD_URI = 2'd1,
		FLD_VERSION = 2'd2,
		FLD_CLOSED = 2'd3
	} field_t;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_NOT_IMPL = 2'd1,
		ST_BAD = 2'd2
	} status_t;

	function automatic logic get_ok(logic [POS_W-1:0] pos, logic [7:0] b);
		case (pos)
			4'd0: get_ok = (b == "G");
			4'd1: get_ok = (b == "E");
			4'd2: get_ok = (b == "T");
			default: get_ok = 1'b0;
		endcase
	endfunction

	function automatic logic post_ok(logic [POS_W-1:0] pos, logic [7:0] b);
		case (pos)
			4'd0: post_ok = (b == "P");
			4'd1: post_ok = (b == "O");
			4'd2: post_ok = (b == "S");
			4'd3: post_ok = (b == "T");
			default: post_ok = 1'b0;
		endcase
	endfunction

	function automatic logic head_ok(logic [POS_W-1:0] pos, logic [7:0] b);
		case (pos)
			4'd0: head_ok = (b == "H");
			4'd1: head_ok = (b == "E");
			4'd2: head_ok = (b == "A");
			4'd3: head_ok = (b == "D");
			default: head_ok = 1'b0;
		endcase
	endfunction

	function automatic logic ver_ok(logic [POS_W-1:0] pos, logic [7:0] b);
		case (pos)
			4'd0: ver_ok = (b == "H");
			4'd1: ver_ok = (b == "T");
			4'd2: ver_ok = (b == "T");
			4'd3: ver_ok = (b == "P");
			4'd4: ver_ok = (b == "/");
			4'd5: ver_ok = (b == "1");
			4'd6: ver_ok = (b == ".");
			4'd7: ver_ok = (b == "1");
			default: ver_ok = 1'b0;
		endcase
	endfunction

endpackage

### hdl/http_request_line_check_top.sv
// Checks the request line of an HTTP request, one received byte per item, and
// returns one verdict on the item marked by tlast: status 0 good, 1 method not
// implemented, 2 bad request, with the count of fields closed by a delimiter.
// Fields split at space, CR and LF; the method must be GET, POST or HEAD, the
// URI must start with '/' and the version must be HTTP/1.1. Bytes after the
// first CR or LF, or after the third delimiter, are ignored. The field tracker
// updates in the cycle of acceptance and a verdict lands in the output
// register, which can be drained while the next byte is taken. Items without
// tlast give no result; after a tlast item the checker returns to its initial
// state for the next buffer.
module http_request_line_check_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [1:0] status, [3:2] fields_found, [7:4] zero
);
	import hrlc_pkg::*;

	field_t            field_q, field_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [2:0]        method_q, method_d;
	logic              uri_ok_q, uri_ok_d;
	logic              ver_q, ver_d;
	logic              done_q, done_d;
	status_t           verdict_q, verdict_d;

	logic              m_valid_q;
	status_t           status_q;
	logic [1:0]        found_q;
	status_t           status_d;

	logic              accept;
	logic              delim;
	logic              hit;

	assign s_tready = !m_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign delim = (s_tdata == CH_SPACE) || (s_tdata == CH_CR) || (s_tdata == CH_LF);
	assign hit = ((method_q[0]) && (pos_q == GET_LEN)) ||
		((method_q[1]) && (pos_q == POST_LEN)) ||
		((method_q[2]) && (pos_q == HEAD_LEN));

	always_comb begin
		field_d = field_q;
		pos_d = pos_q;
		method_d = method_q;
		uri_ok_d = uri_ok_q;
		ver_d = ver_q;
		done_d = done_q;
		verdict_d = verdict_q;
		if (!done_q) begin
			if (delim) begin
				case (field_q)
					FLD_METHOD: begin
						if (pos_q == '0)
							verdict_d = ST_BAD;
						else
							verdict_d = hit ? ST_GOOD : ST_NOT_IMPL;
					end
					FLD_VERSION: begin
						if (!uri_ok_q || !(ver_q && (pos_q == VER_LEN)))
							verdict_d = ST_BAD;
					end
					default: ;
				endcase
				field_d = field_t'(field_q + 2'd1);
				pos_d = '0;
				if ((s_tdata != CH_SPACE) || (field_d == FLD_CLOSED))
					done_d = 1'b1;
			end else begin
				case (field_q)
					FLD_METHOD: begin
						if (!get_ok(pos_q, s_tdata))
							method_d = method_d & ~M_GET;
						if (!post_ok(pos_q, s_tdata))
							method_d = method_d & ~M_POST;
						if (!head_ok(pos_q, s_tdata))
							method_d = method_d & ~M_HEAD;
					end
					FLD_URI: begin
						if (pos_q == '0)
							uri_ok_d = (s_tdata == CH_SLASH);
					end
					FLD_VERSION: begin
						if (!ver_ok(pos_q, s_tdata))
							ver_d = 1'b0;
					end
					default: ;
				endcase
				if (pos_q != POS_MAX)
					pos_d = pos_q + POS_W'(1);
			end
		end
		status_d = (done_d && (field_d == FLD_CLOSED)) ? verdict_d : ST_BAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= FLD_METHOD;
			pos_q <= '0;
			method_q <= M_GET | M_POST | M_HEAD;
			uri_ok_q <= 1'b0;
			ver_q <= 1'b1;
			done_q <= 1'b0;
			verdict_q <= ST_BAD;
		end else if (accept) begin
			if (s_tlast) begin
				field_q <= FLD_METHOD;
				pos_q <= '0;
				method_q <= M_GET | M_POST | M_HEAD;
				uri_ok_q <= 1'b0;
				ver_q <= 1'b1;
				done_q <= 1'b0;
				verdict_q <= ST_BAD;
			end else begin
				field_q <= field_d;
				pos_q <= pos_d;
				method_q <= method_d;
				uri_ok_q <= uri_ok_d;
				ver_q <= ver_d;
				done_q <= done_d;
				verdict_q <= verdict_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept && s_tlast) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			status_q <= status_d;
			found_q <= field_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {4'b0000, found_q, status_q};

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> m_tvalid && (field_q == FLD_METHOD) && (pos_q == '0) && !done_q)
		else $error("tracker not restarted after last item");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_valid_q)
		else $error("input stalled with empty output register");

	a_frozen_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && accept && !s_tlast |=> $stable(field_q) && $stable(verdict_q) && done_q)
		else $error("frozen request line changed");

	a_good_has_three: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ST_GOOD) |-> (m_tdata[3:2] == 2'd3))
		else $error("good verdict with fewer than three fields");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q && !(accept && s_tlast) |=> !m_tvalid)
		else $error("result without a last item");

endmodule

### sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hrlc_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [1:0] fields;
	} verdict_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       pin;
		status_t    st;
		logic [1:0] nf;
	} dir_row_t;

	localparam int STUCK_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 440;
	localparam verdict_t NO_PIN = '{ST_BAD, 2'd0};
	localparam logic [63:0] TXT_GET = "GET";
	localparam logic [63:0] TXT_POST = "POST";
	localparam logic [63:0] TXT_HEAD = "HEAD";
	localparam logic [63:0] TXT_VER = "HTTP/1.1";

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;

	logic       pin_on;
	verdict_t   pin_v;
	logic       hold_req = 1'b0;
	int         send_idle = 0;
	int         sink_stall = 0;
	int         errors = 0;
	int         stuck = 0;
	int         byte_count = 0;

	verdict_t   verdicts_due[$];
	logic [7:0] req_bytes[$];
	dir_row_t   dir_tab[22];

	field_t     ln_field;
	logic [3:0] ln_pos;
	logic [2:0] ln_methods;
	logic       ln_uri_slash;
	logic       ln_ver_ok;
	logic       ln_frozen;
	status_t    ln_verdict;

	http_request_line_check_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic text_char_ok(logic [63:0] txt, int len, logic [3:0] p,
			logic [7:0] b);
		if (int'(p) >= len)
			return 1'b0;
		return txt[8*(len-1-int'(p)) +: 8] == b;
	endfunction

	function automatic logic [7:0] any_char();
		return 8'($urandom_range(33, 126));
	endfunction

	task automatic clear_line();
		ln_field = FLD_METHOD;
		ln_pos = '0;
		ln_methods = M_GET | M_POST | M_HEAD;
		ln_uri_slash = 1'b0;
		ln_ver_ok = 1'b1;
		ln_frozen = 1'b0;
		ln_verdict = ST_BAD;
	endtask

	task automatic scan_request_byte(input logic [7:0] b, input logic l, output logic got,
			output verdict_t v);
		logic hit;
		got = 1'b0;
		v = NO_PIN;
		if (!ln_frozen) begin
			if (b == CH_SPACE || b == CH_CR || b == CH_LF) begin
				if (ln_field == FLD_METHOD) begin
					hit = (ln_methods[0] && ln_pos == GET_LEN) ||
						(ln_methods[1] && ln_pos == POST_LEN) ||
						(ln_methods[2] && ln_pos == HEAD_LEN);
					if (ln_pos == '0)
						ln_verdict = ST_BAD;
					else
						ln_verdict = hit ? ST_GOOD : ST_NOT_IMPL;
				end else if (ln_field == FLD_VERSION) begin
					if (!ln_uri_slash || !(ln_ver_ok && ln_pos == VER_LEN))
						ln_verdict = ST_BAD;
				end
				ln_field = field_t'(ln_field + 2'd1);
				ln_pos = '0;
				if (b != CH_SPACE || ln_field == FLD_CLOSED)
					ln_frozen = 1'b1;
			end else begin
				case (ln_field)
					FLD_METHOD: begin
						if (!text_char_ok(TXT_GET, int'(GET_LEN), ln_pos, b))
							ln_methods &= ~M_GET;
						if (!text_char_ok(TXT_POST, int'(POST_LEN), ln_pos, b))
							ln_methods &= ~M_POST;
						if (!text_char_ok(TXT_HEAD, int'(HEAD_LEN), ln_pos, b))
							ln_methods &= ~M_HEAD;
					end
					FLD_URI: begin
						if (ln_pos == '0)
							ln_uri_slash = (b == CH_SLASH);
					end
					FLD_VERSION: begin
						if (!text_char_ok(TXT_VER, int'(VER_LEN), ln_pos, b))
							ln_ver_ok = 1'b0;
					end
					default: ;
				endcase
				if (ln_pos != POS_MAX)
					ln_pos = ln_pos + 4'd1;
			end
		end
		if (l) begin
			got = 1'b1;
			v.status = (ln_frozen && ln_field == FLD_CLOSED) ? ln_verdict : ST_BAD;
			v.fields = ln_field;
			clear_line();
		end
	endtask

	always @(posedge clk) begin
		verdict_t want;
		verdict_t pred;
		logic got;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual data %h",
					$time, m_tdata);
				errors++;
			end else begin
				want = verdicts_due.pop_front();
				if (m_tdata[1:0] !== want.status || m_tdata[3:2] !== want.fields ||
						m_tdata[7:4] !== 4'd0) begin
					$display("%0t: expected status %0d fields %0d, actual status %0d fields %0d pad %h",
						$time, want.status, want.fields, m_tdata[1:0], m_tdata[3:2],
						m_tdata[7:4]);
					errors++;
				end
			end
		end
		if (s_tvalid && s_tready === 1'b1) begin
			scan_request_byte(s_tdata, s_tlast, got, pred);
			if (got)
				verdicts_due.push_back(pin_on ? pin_v : pred);
		end
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall);
			end
		end
	end

	task automatic offer_item(input logic [7:0] b, input logic l, input logic pin,
			input verdict_t pv);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		pin_on <= pin;
		pin_v <= pv;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_field(input string s, input int clean_pct);
		int flip;
		int keep;
		int extra;
		flip = -1;
		keep = s.len();
		extra = 0;
		if ($urandom_range(99) >= clean_pct) begin
			case ($urandom_range(2))
				0: flip = $urandom_range(s.len() - 1);
				1: keep = $urandom_range(s.len() - 1);
				default: extra = $urandom_range(1, 12);
			endcase
		end
		for (int i = 0; i < keep; i++)
			req_bytes.push_back(i == flip ? any_char() : s[i]);
		repeat (extra) req_bytes.push_back(any_char());
	endtask

	task automatic random_request();
		int kind;
		int cut;
		req_bytes.delete();
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 24)) req_bytes.push_back(8'($urandom_range(255)));
		end else begin
			if ($urandom_range(99) < 8) begin
				repeat ($urandom_range(0, 18)) req_bytes.push_back(any_char());
			end else begin
				case ($urandom_range(2))
					0: add_field("GET", 80);
					1: add_field("POST", 80);
					default: add_field("HEAD", 80);
				endcase
			end
			if ($urandom_range(99) < 95)
				req_bytes.push_back(CH_SPACE);
			if ($urandom_range(99) < 90)
				req_bytes.push_back($urandom_range(99) < 85 ? CH_SLASH : any_char());
			repeat ($urandom_range(0, 6)) req_bytes.push_back(any_char());
			if ($urandom_range(99) < 95)
				req_bytes.push_back(CH_SPACE);
			if ($urandom_range(99) < 8) begin
				repeat ($urandom_range(0, 18)) req_bytes.push_back(any_char());
			end else begin
				add_field("HTTP/1.1", 75);
			end
			case ($urandom_range(3))
				0: req_bytes.push_back(CH_CR);
				1: req_bytes.push_back(CH_LF);
				2: req_bytes.push_back(CH_SPACE);
				default: begin
					req_bytes.push_back(CH_CR);
					req_bytes.push_back(CH_LF);
				end
			endcase
			repeat ($urandom_range(0, 4)) req_bytes.push_back(8'($urandom_range(255)));
			if (kind < 25) begin
				cut = $urandom_range(1, req_bytes.size());
				while (req_bytes.size() > cut)
					void'(req_bytes.pop_back());
			end
		end
		foreach (req_bytes[i])
			offer_item(req_bytes[i], i == req_bytes.size() - 1, 1'b0, NO_PIN);
		byte_count += req_bytes.size();
	endtask

	initial begin
		verdict_t pv;
		int phase_end;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		pin_on = 1'b0;
		pin_v = NO_PIN;
		clear_line();
		dir_tab = '{
			'{8'h00,    1'b1, 1'b1, ST_BAD,  2'd0},
			'{8'hff,    1'b1, 1'b1, ST_BAD,  2'd0},
			'{CH_CR,    1'b1, 1'b1, ST_BAD,  2'd1},
			'{CH_LF,    1'b1, 1'b1, ST_BAD,  2'd1},
			'{CH_SPACE, 1'b0, 1'b0, ST_GOOD, 2'd0},
			'{CH_SPACE, 1'b0, 1'b0, ST_GOOD, 2'd0},
			'{CH_SPACE, 1'b1, 1'b1, ST_BAD,  2'd3},
			'{"G",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"E",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"T",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{CH_SPACE, 1'b0, 1'b0, ST_GOOD, 2'd0},
			'{CH_SLASH, 1'b0, 1'b0, ST_GOOD, 2'd0},
			'{CH_SPACE, 1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"H",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"T",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"T",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"P",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"/",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"1",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{".",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{"1",      1'b0, 1'b0, ST_GOOD, 2'd0},
			'{CH_LF,    1'b1, 1'b1, ST_GOOD, 2'd3}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_tab[i]) begin
			pv.status = dir_tab[i].st;
			pv.fields = dir_tab[i].nf;
			offer_item(dir_tab[i].b, dir_tab[i].l, dir_tab[i].pin, pv);
		end
		drain_results();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle = 0;
					sink_stall = 0;
				end
				1: begin
					send_idle = 82;
					sink_stall = 0;
				end
				2: begin
					send_idle = 0;
					sink_stall = 82;
				end
				default: begin
					send_idle = 13;
					sink_stall = 13;
				end
			endcase
			phase_end = byte_count + PHASE_BYTES;
			while (byte_count < phase_end)
				random_request();
			drain_results();
			if (ph == 0) begin
				hold_req = 1'b1;
				repeat (40) offer_item(8'($urandom_range(255)), 1'b1, 1'b0, NO_PIN);
				drain_results();
			end
		end
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### http_request_line_check_top.f
hdl/hrlc_pkg.sv
hdl/http_request_line_check_top.sv
sim/tb.sv
